// ===== hdl/pidc_pkg.sv =====
// Shared types and constants for the clamped PID controller.
package pidc_pkg;

  // Default sizes, Q(DATA_WIDTH-FRAC_BITS).FRAC_BITS
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Error filter weight: Q1.16, unsigned, one is 1 << 16
  localparam int          COEF_W    = 17;
  localparam int          COEF_FRAC = 16;
  localparam logic [16:0] COEF_ONE  = 17'h10000;

  // Whole part output width
  localparam int WHOLE_W = 16;

  // Configuration register index
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN      = 3'd0,
    REG_INTEGRAL_GAIN  = 3'd1,
    REG_DERIV_GAIN     = 3'd2,
    REG_FILTER_COEF    = 3'd3,
    REG_INTEGRAL_LIMIT = 3'd4,
    REG_OUTPUT_LIMIT   = 3'd5,
    REG_DERIV_MODE     = 3'd6
  } reg_idx_e;

  // Control step sequencer
  typedef enum logic [3:0] {
    S_IDLE,
    S_FLOAD,
    S_FMUL,
    S_FADD,
    S_INTEG,
    S_PMUL,
    S_ILOAD,
    S_IMUL,
    S_DLOAD,
    S_DMUL,
    S_DADD,
    S_CLAMP,
    S_OUT
  } state_e;

endpackage

// ===== hdl/pidc_req_if.sv =====
// Request channel: target, measurement and gyro rate.
interface pidc_req_if #(
  parameter int DATA_WIDTH = pidc_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] target;
  logic signed [DATA_WIDTH-1:0] measured;
  logic signed [DATA_WIDTH-1:0] gyro_rate;

  modport source (output valid, output target, output measured, output gyro_rate,
                  input ready);
  modport sink   (input valid, input target, input measured, input gyro_rate,
                  output ready);
endinterface

// ===== hdl/pidc_res_if.sv =====
// Result channel: clamped drive and its whole part.
interface pidc_res_if #(
  parameter int DATA_WIDTH = pidc_pkg::DATA_WIDTH_DEF
);
  import pidc_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] drive;
  logic signed [WHOLE_W-1:0]    drive_whole;

  modport source (output valid, output drive, output drive_whole, input ready);
  modport sink   (input valid, input drive, input drive_whole, output ready);
endinterface

// ===== hdl/pid_controller_clamped.sv =====
// Clamped PID controller with a shared bit-serial shift-add multiplier.
// Each product (filter, P, I, D) runs on an MW-bit multiplier, one multiplier bit
//   per cycle, MW = max(DATA_WIDTH, 18); mode 1 skips the filter product.
// A new request is taken only when idle, once the previous step has finished.
// A finished result waits in the output register while the next request runs.
// Reset (async, active low) clears the configuration registers, state, result valid, integral and last error.
module pid_controller_clamped #(
  parameter int DATA_WIDTH = pidc_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = pidc_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [((DATA_WIDTH > pidc_pkg::COEF_W) ? DATA_WIDTH
                 : pidc_pkg::COEF_W)-1:0]     cfg_data_i,
  pidc_req_if.sink                            req_i,
  pidc_res_if.source                          res_o
);
  import pidc_pkg::*;

  localparam int DW    = DATA_WIDTH;
  localparam int FB    = FRAC_BITS;
  localparam int EW    = DW + 1;
  localparam int MW    = (DW > COEF_W) ? DW : COEF_W + 1;
  localparam int PW    = EW + MW;
  localparam int SW    = PW + 2;
  localparam int CNT_W = $clog2(MW);
  localparam int QW    = DW - FB;
  localparam int XW    = (QW > WHOLE_W) ? QW : WHOLE_W;

  // Configuration registers
  logic signed [DW-1:0]     kp_q, ki_q, kd_q;
  logic [COEF_W-1:0]        coef_q;
  logic [DW-2:0]            ilim_q, olim_q;
  logic                     mode_q;

  // Controller state and working registers
  state_e                   state_q, state_d;
  logic signed [DW-1:0]     err_q, err_d;
  logic signed [DW-1:0]     prev_q, prev_d;
  logic signed [DW-1:0]     int_q, int_d;
  logic signed [DW-1:0]     gyro_q, gyro_d;
  logic signed [PW-1:0]     mcand_q, mcand_d;
  logic [MW-1:0]            mplier_q, mplier_d;
  logic signed [PW-1:0]     acc_q, acc_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic signed [SW-1:0]     sum_q, sum_d;
  logic signed [DW-1:0]     drive_q, drive_d;
  logic                     res_valid_q, res_valid_d;
  logic signed [DW-1:0]     res_drive_q, res_drive_d;
  logic signed [WHOLE_W-1:0] res_whole_q, res_whole_d;

  logic                     req_accept;

  // Error with saturation
  logic signed [EW-1:0]     diff;
  logic signed [DW-1:0]     err_sat;

  // Multiplier step and operands
  logic signed [PW-1:0]     addend;
  logic                     mul_last;
  logic                     mul_load;
  logic signed [EW-1:0]     ld_mcand;
  logic [MW-1:0]            ld_mplier;
  logic [COEF_W-1:0]        coef_eff;

  // Derived terms
  logic signed [EW-1:0]     err_x, prev_x, int_x;
  logic signed [EW-1:0]     filt_term;
  logic signed [SW-1:0]     gain_term;
  logic signed [EW-1:0]     int_sum, ilim_x;
  logic signed [DW-1:0]     int_clamp;
  logic signed [SW-1:0]     olim_x;
  logic signed [DW-1:0]     sum_clamp;
  logic signed [DW-1:0]     drive_adj;
  logic signed [QW-1:0]     whole_q;
  logic signed [XW-1:0]     whole_x;
  logic signed [WHOLE_W-1:0] whole_sat;

  assign req_i.ready       = (state_q == S_IDLE);
  assign req_accept        = req_i.valid && req_i.ready;
  assign res_o.valid       = res_valid_q;
  assign res_o.drive       = res_drive_q;
  assign res_o.drive_whole = res_whole_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q   <= '0;
      ki_q   <= '0;
      kd_q   <= '0;
      coef_q <= '0;
      ilim_q <= '0;
      olim_q <= '0;
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PROP_GAIN:      kp_q   <= cfg_data_i[DW-1:0];
        REG_INTEGRAL_GAIN:  ki_q   <= cfg_data_i[DW-1:0];
        REG_DERIV_GAIN:     kd_q   <= cfg_data_i[DW-1:0];
        REG_FILTER_COEF:    coef_q <= cfg_data_i[COEF_W-1:0];
        REG_INTEGRAL_LIMIT: ilim_q <= cfg_data_i[DW-2:0];
        REG_OUTPUT_LIMIT:   olim_q <= cfg_data_i[DW-2:0];
        REG_DERIV_MODE:     mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // target - measured, saturated to the data range
  assign diff = EW'(req_i.target) - EW'(req_i.measured);
  always_comb begin
    if (diff[EW-1] != diff[EW-2]) begin
      err_sat = diff[EW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      err_sat = diff[DW-1:0];
    end
  end

  // Shift-add step: sign bit of the multiplier carries negative weight
  assign addend   = mplier_q[0] ? mcand_q : '0;
  assign mul_last = (cnt_q == CNT_W'(MW - 1));
  assign coef_eff = (coef_q > COEF_ONE) ? COEF_ONE : coef_q;

  assign err_x  = EW'(err_q);
  assign prev_x = EW'(prev_q);
  assign int_x  = EW'(int_q);

  // Filter: err + floor(coef * (prev - err) / 2^16)
  assign filt_term = EW'(acc_q >>> COEF_FRAC);
  // Gain product shifted down, floor rounding
  assign gain_term = SW'(acc_q >>> FB);

  // Integral clamp
  assign int_sum = int_x + err_x;
  assign ilim_x  = EW'({1'b0, ilim_q});
  always_comb begin
    if (int_sum > ilim_x) begin
      int_clamp = DW'(ilim_x);
    end else if (int_sum < -ilim_x) begin
      int_clamp = DW'(-ilim_x);
    end else begin
      int_clamp = DW'(int_sum);
    end
  end

  // Output clamp
  assign olim_x = SW'({1'b0, olim_q});
  always_comb begin
    if (sum_q > olim_x) begin
      sum_clamp = DW'(olim_x);
    end else if (sum_q < -olim_x) begin
      sum_clamp = DW'(-olim_x);
    end else begin
      sum_clamp = DW'(sum_q);
    end
  end

  // Whole part, truncated toward zero, saturated to 16 bits
  assign drive_adj = drive_q[DW-1] ? drive_q + DW'((1 << FB) - 1) : drive_q;
  assign whole_q   = QW'(drive_adj >>> FB);
  assign whole_x   = XW'(whole_q);
  always_comb begin
    if (whole_x > XW'(16'sh7fff)) begin
      whole_sat = 16'sh7fff;
    end else if (whole_x < XW'(16'sh8000)) begin
      whole_sat = 16'sh8000;
    end else begin
      whole_sat = WHOLE_W'(whole_x);
    end
  end

  // Sequencer: next state and datapath control
  always_comb begin
    state_d     = state_q;
    err_d       = err_q;
    prev_d      = prev_q;
    int_d       = int_q;
    gyro_d      = gyro_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    drive_d     = drive_q;
    res_valid_d = res_valid_q;
    res_drive_d = res_drive_q;
    res_whole_d = res_whole_q;
    mul_load    = 1'b0;
    ld_mcand    = err_x;
    ld_mplier   = MW'(kp_q);

    if (res_valid_q && res_o.ready) begin
      res_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_accept) begin
          err_d   = err_sat;
          gyro_d  = req_i.gyro_rate;
          state_d = mode_q ? S_INTEG : S_FLOAD;
        end
      end
      S_FLOAD: begin
        mul_load  = 1'b1;
        ld_mcand  = prev_x - err_x;
        ld_mplier = MW'(coef_eff);
        state_d   = S_FMUL;
      end
      S_FADD: begin
        err_d   = DW'(err_x + filt_term);
        state_d = S_INTEG;
      end
      S_INTEG: begin
        int_d     = int_clamp;
        mul_load  = 1'b1;
        ld_mcand  = err_x;
        ld_mplier = MW'(kp_q);
        state_d   = S_PMUL;
      end
      S_ILOAD: begin
        sum_d     = gain_term;
        mul_load  = 1'b1;
        ld_mcand  = int_x;
        ld_mplier = MW'(ki_q);
        state_d   = S_IMUL;
      end
      S_DLOAD: begin
        sum_d     = sum_q + gain_term;
        mul_load  = 1'b1;
        ld_mcand  = mode_q ? EW'(gyro_q) : (err_x - prev_x);
        ld_mplier = MW'(kd_q);
        state_d   = S_DMUL;
      end
      S_FMUL, S_PMUL, S_IMUL, S_DMUL: begin
        acc_d    = mul_last ? acc_q - addend : acc_q + addend;
        mcand_d  = mcand_q <<< 1;
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q + CNT_W'(1);
        if (mul_last) begin
          unique case (state_q)
            S_FMUL:  state_d = S_FADD;
            S_PMUL:  state_d = S_ILOAD;
            S_IMUL:  state_d = S_DLOAD;
            default: state_d = S_DADD;
          endcase
        end
      end
      S_DADD: begin
        // gyro mode negates the floored product
        sum_d   = mode_q ? sum_q - gain_term : sum_q + gain_term;
        state_d = S_CLAMP;
      end
      S_CLAMP: begin
        drive_d = sum_clamp;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!res_valid_q || res_o.ready) begin
          res_valid_d = 1'b1;
          res_drive_d = drive_q;
          res_whole_d = whole_sat;
          prev_d      = err_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Multiplier start: load operands, clear accumulator and counter
    if (mul_load) begin
      mcand_d  = PW'(ld_mcand);
      mplier_d = ld_mplier;
      acc_d    = '0;
      cnt_d    = '0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
      int_q       <= '0;
      prev_q      <= '0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      int_q       <= int_d;
      prev_q      <= prev_d;
      cnt_q       <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    err_q       <= err_d;
    gyro_q      <= gyro_d;
    mcand_q     <= mcand_d;
    mplier_q    <= mplier_d;
    acc_q       <= acc_d;
    sum_q       <= sum_d;
    drive_q     <= drive_d;
    res_drive_q <= res_drive_d;
    res_whole_q <= res_whole_d;
  end

endmodule

// ===== hdl/pidc_chk.sv =====
// Port-level assertions for the PID controller, bound to the top level.
module pidc_chk #(
  parameter int DATA_WIDTH = pidc_pkg::DATA_WIDTH_DEF
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              req_valid_i,
  input logic                              req_ready_i,
  input logic                              res_valid_i,
  input logic                              res_ready_i,
  input logic [DATA_WIDTH-1:0]             res_drive_i,
  input logic [pidc_pkg::WHOLE_W-1:0]      res_whole_i
);
  import pidc_pkg::*;

  // A stalled result holds its value
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_drive_i)
      && $stable(res_whole_i))
    else $error("result changed while stalled");

  // A negative whole part needs a negative drive
  a_whole_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_whole_i[WHOLE_W-1] |-> res_drive_i[DATA_WIDTH-1])
    else $error("whole part sign disagrees with drive");

  // One step at a time: busy right after a request is taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while a step is running");

  // A new result appears only as the step finishes and the block goes idle
  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> req_ready_i)
    else $error("result raised while busy");

endmodule

bind pid_controller_clamped pidc_chk #(.DATA_WIDTH(DATA_WIDTH)) u_pidc_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_drive_i (res_o.drive),
  .res_whole_i (res_o.drive_whole)
);

// ===== dv/tb_pid_controller_clamped.sv =====
// Testbench for the clamped PID controller: scoreboard with a step predictor and random traffic.
`timescale 1ns / 100ps

module tb_pid_controller_clamped;
  import pidc_pkg::*;

  localparam int DATA_WIDTH  = DATA_WIDTH_DEF;
  localparam int FRAC_BITS   = FRAC_BITS_DEF;
  localparam int STALL_LIMIT = 4000;  // cycles without any request or result moving
  localparam int HOLD_CYCLES = 700;   // long result back-pressure stretch
  localparam int DRAIN_WAIT  = 150;   // idle wait for stray results before the verdict
  localparam int RAND_PHASES = 16;
  localparam int PHASE_ITEMS = 50;

  // Controller settings as held in the block
  typedef struct {
    logic signed [31:0] kp;
    logic signed [31:0] ki;
    logic signed [31:0] kd;
    logic [16:0]        coef;
    logic [30:0]        ilim;
    logic [30:0]        olim;
    logic               mode;
  } pid_cfg_t;

  typedef struct {
    logic signed [31:0] drive;
    logic signed [15:0] whole;
  } drive_exp_t;

  // Step predictor plus queue of expected drive values
  class pid_scoreboard;
    pid_cfg_t   cfg;
    longint     integ;
    longint     last_err;
    drive_exp_t drive_q[$];
    int         mismatches;

    function new();
      cfg        = '{default: '0};
      integ      = 0;
      last_err   = 0;
      mismatches = 0;
    endfunction

    function void set_config(pid_cfg_t c);
      cfg = c;
    endfunction

    // floor(a * b / 2^sh) at full width
    function longint mul_floor(longint a, longint b, int sh);
      logic signed [127:0] wa, wb, prod;
      wa   = a;
      wb   = b;
      prod = wa * wb;
      return longint'(prod >>> sh);
    endfunction

    function longint clamp_sym(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    // One control step: updates integral and last error, returns the drive
    function drive_exp_t run_step(logic signed [31:0] tgt, logic signed [31:0] meas,
                                  logic signed [31:0] gyro);
      longint     err, coef, filt, deriv, sum, drv, whole;
      drive_exp_t res;
      err = longint'(tgt) - longint'(meas);
      if (err > 64'sd2147483647) err = 64'sd2147483647;
      if (err < -64'sd2147483648) err = -64'sd2147483648;
      if (cfg.coef > COEF_ONE) coef = longint'(COEF_ONE);
      else coef = longint'(cfg.coef);
      // Low-pass against last error, skipped in gyro mode
      if (cfg.mode == 1'b0) begin
        filt = (longint'(COEF_ONE) - coef) * err + coef * last_err;
        err  = mul_floor(filt, 1, COEF_FRAC);
      end
      integ = clamp_sym(integ + err, longint'(cfg.ilim));
      if (cfg.mode == 1'b0) deriv = mul_floor(cfg.kd, err - last_err, FRAC_BITS);
      else deriv = -mul_floor(cfg.kd, gyro, FRAC_BITS);
      sum = mul_floor(cfg.kp, err, FRAC_BITS) + mul_floor(cfg.ki, integ, FRAC_BITS) + deriv;
      drv = clamp_sym(sum, longint'(cfg.olim));
      last_err = err;
      // Integer part, toward zero, saturated to 16 bits
      whole = drv / (longint'(1) << FRAC_BITS);
      if (whole > 32767) whole = 32767;
      if (whole < -32768) whole = -32768;
      res.drive = drv[31:0];
      res.whole = whole[15:0];
      return res;
    endfunction

    function void note_request(logic signed [31:0] tgt, logic signed [31:0] meas,
                               logic signed [31:0] gyro);
      drive_q.push_back(run_step(tgt, meas, gyro));
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("ERROR: %s", msg);
    endfunction

    function void check_result(logic signed [31:0] drive, logic signed [15:0] whole);
      drive_exp_t exp_r;
      if (drive_q.size() == 0) begin
        report($sformatf("result with nothing pending: drive=%0d whole=%0d", drive, whole));
        return;
      end
      exp_r = drive_q.pop_front();
      if (exp_r.drive !== drive)
        report($sformatf("drive: expected %0d, got %0d", exp_r.drive, drive));
      if (exp_r.whole !== whole)
        report($sformatf("drive_whole: expected %0d, got %0d", exp_r.whole, whole));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [31:0] cfg_data;
  int          gap_max;

  pid_scoreboard sb;

  pidc_req_if #(.DATA_WIDTH(DATA_WIDTH)) req_if ();
  pidc_res_if #(.DATA_WIDTH(DATA_WIDTH)) res_if ();

  pid_controller_clamped #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .req_i     (req_if),
    .res_o     (res_if)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Random picks: moderate values, some extremes, some full range
  function automatic logic [31:0] pick_gain();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        default: return 32'h0001_0000;
      endcase
    end
    if (sel < 7) return int'($urandom_range(0, 524288)) - 262144;
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_sample();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    if (sel < 6) return int'($urandom_range(0, 2097152)) - 1048576;
    return $urandom;
  endfunction

  function automatic logic [30:0] pick_limit();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return ($urandom_range(0, 1) == 0) ? 31'h0 : 31'h7fff_ffff;
    if (sel < 6) return 31'($urandom_range(0, 32'h0100_0000));
    return 31'($urandom);
  endfunction

  function automatic logic [16:0] pick_coef();
    case ($urandom_range(0, 4))
      0: return 17'h0;
      1: return COEF_ONE;
      2: return 17'h1ffff;
      3: return 17'($urandom_range(0, 65536));
      default: return 17'($urandom);
    endcase
  endfunction

  function automatic pid_cfg_t make_cfg(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                                        logic [16:0] coef, logic [30:0] ilim,
                                        logic [30:0] olim, logic mode);
    pid_cfg_t c;
    c.kp   = kp;
    c.ki   = ki;
    c.kd   = kd;
    c.coef = coef;
    c.ilim = ilim;
    c.olim = olim;
    c.mode = mode;
    return c;
  endfunction

  // Register write; the caller lowers the write enable after the last one
  task automatic put_reg(reg_idx_e idx, logic [31:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
  endtask

  task automatic load_gains(pid_cfg_t c);
    put_reg(REG_PROP_GAIN, c.kp);
    put_reg(REG_INTEGRAL_GAIN, c.ki);
    put_reg(REG_DERIV_GAIN, c.kd);
    put_reg(REG_FILTER_COEF, {15'b0, c.coef});
    put_reg(REG_INTEGRAL_LIMIT, {1'b0, c.ilim});
    put_reg(REG_OUTPUT_LIMIT, {1'b0, c.olim});
    put_reg(REG_DERIV_MODE, {31'b0, c.mode});
    cfg_we <= 1'b0;
    sb.set_config(c);
  endtask

  // Offer one request after a random gap; valid stays high on return
  task automatic send_step(logic [31:0] tgt, logic [31:0] meas, logic [31:0] gyro);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.target    <= tgt;
    req_if.measured  <= meas;
    req_if.gyro_rate <= gyro;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sb.note_request(tgt, meas, gyro);
  endtask

  // Stop offering and wait for every pending result
  task automatic drain();
    req_if.valid <= 1'b0;
    while (sb.drive_q.size() != 0) @(posedge clk_i);
  endtask

  // Result side: random stalls, two long holds to back up the block
  initial begin : result_sink
    int gap;
    int seen;
    seen         = 0;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, gap_max);
      if (seen == 40 || seen == 500) gap = HOLD_CYCLES;
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_if.valid) @(posedge clk_i);
      sb.check_result(res_if.drive, res_if.drive_whole);
      seen++;
    end
  end

  // Watchdog on cycles where nothing moves
  initial begin : watchdog
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) stall = 0;
      else stall++;
    end
    $display("ERROR: no progress for %0d cycles", STALL_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // Stimulus
  initial begin : stimulus
    logic [31:0] setpoint;
    logic [31:0] tgt;
    logic [31:0] meas;
    sb               = new();
    gap_max          = 4;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_data         = '0;
    req_if.valid     = 1'b0;
    req_if.target    = '0;
    req_if.measured  = '0;
    req_if.gyro_rate = '0;
    rst_ni           = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: all gains and limits zero
    send_step(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_step(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    drain();

    // Plain PID, no filter; error saturation both ways, negative fractions
    load_gains(make_cfg(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 17'h0,
                        31'h0064_0000, 31'h7fff_ffff, 1'b0));
    send_step(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_step(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000);
    send_step(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000);
    send_step(32'h0001_8000, 32'h0000_4000, 32'h1234_5678);
    send_step(32'hfffd_0000, 32'h0005_0000, 32'h0000_0000);
    send_step(32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff);
    drain();

    // Filter weight of one, extreme gains, tight output clamp
    load_gains(make_cfg(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, COEF_ONE,
                        31'h7fff_ffff, 31'h0001_0000, 1'b0));
    send_step(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000);
    send_step(32'h0000_1000, 32'h0000_0000, 32'h0000_0000);
    send_step(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000);
    send_step(32'h0000_0000, 32'h0000_0001, 32'h0000_0000);
    drain();

    // Filter weight above one, zero integral limit
    load_gains(make_cfg(32'h0002_0000, 32'h7fff_ffff, 32'h0001_0000, 17'h1ffff,
                        31'h0, 31'h7fff_ffff, 1'b0));
    send_step(32'h0010_0000, 32'h0000_0000, 32'h0000_0000);
    send_step(32'hfff0_0000, 32'h0000_0000, 32'h0000_0000);
    send_step(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000);
    drain();

    // Gyro mode, filter weight ignored, gyro extremes
    load_gains(make_cfg(32'h0001_0000, 32'h0000_8000, 32'h8000_0000, 17'h0_8000,
                        31'h7fff_ffff, 31'h7fff_ffff, 1'b1));
    send_step(32'h0003_0000, 32'h0001_0000, 32'h8000_0000);
    send_step(32'h0000_0000, 32'h0002_0000, 32'h7fff_ffff);
    send_step(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000);
    send_step(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    drain();

    // Zero output limit
    load_gains(make_cfg(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 17'h0,
                        31'h7fff_ffff, 31'h0, 1'b0));
    send_step(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_step(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    drain();

    // Random settings per phase; items mostly track a setpoint with noise
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      load_gains(make_cfg(pick_gain(), pick_gain(), pick_gain(), pick_coef(),
                          pick_limit(), pick_limit(), 1'($urandom_range(0, 1))));
      gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 4;
      setpoint = pick_sample();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 9) < 7) begin
          tgt  = setpoint;
          meas = setpoint + 32'(int'($urandom_range(0, 262144)) - 131072);
        end else begin
          tgt  = pick_sample();
          meas = pick_sample();
        end
        send_step(tgt, meas, pick_sample());
      end
      drain();
    end

    // Let any stray result show up before the verdict
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.drive_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== pid_controller_clamped.f =====
hdl/pidc_pkg.sv
hdl/pidc_req_if.sv
hdl/pidc_res_if.sv
hdl/pid_controller_clamped.sv
hdl/pidc_chk.sv
dv/tb_pid_controller_clamped.sv
